@@ sv/ipv4hp_pkg.sv @@
// Shared types, constants and character helpers for the IPv4 host:port text parser.
package ipv4hp_pkg;

  localparam int CHAR_W        = 8;
  localparam int VAL_W         = 32;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 16;
  localparam int MAX_PARTS_DEF = 4;

  // Characters with a role in the grammar
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;

  // Digit code for a byte that is no hex digit; above every radix
  localparam logic [4:0] NO_DIGIT = 5'h1F;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'hFFFF_FFFF;

  // Number token scanner state
  typedef enum logic [2:0] {
    TS_START,
    TS_SIGN,
    TS_ZERO,
    TS_ZEROX,
    TS_DIGITS,
    TS_BAD
  } tok_state_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef struct packed {
    tok_state_t       sub;
    base_t            base;
    logic [VAL_W-1:0] value;
    logic             ovf;
    logic             neg;
    logic             len;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{
    sub:   TS_START,
    base:  BASE_DEC,
    value: '0,
    ovf:   1'b0,
    neg:   1'b0,
    len:   1'b0
  };

  // Hex digit value of a byte, NO_DIGIT otherwise
  function automatic logic [4:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d = 5'(c - CH_A_LO + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d = 5'(c - CH_A_UP + 8'd10);
    end
    return d;
  endfunction

  // Space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ sv/ipv4hp_in_if.sv @@
// Text character channel: one character and its end-of-string mark per beat.
interface ipv4hp_in_if;
  import ipv4hp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

@@ sv/ipv4hp_out_if.sv @@
// Result channel: parse status, address and port per beat.
interface ipv4hp_out_if;
  import ipv4hp_pkg::*;

  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [ADDR_W-1:0] address;
  logic [PORT_W-1:0] port;

  modport source (output valid, output valid_res, output address, output port, input ready);
  modport sink   (input valid, input valid_res, input address, input port, output ready);
endinterface

@@ sv/ipv4_host_port_text_parser.sv @@
// Streaming parser of IPv4 "address:port" text into a 32-bit address and 16-bit port.
//
//   channel   dir  beat content                      handshake
//   in_bus    in   character, is_last                valid/ready
//   out_bus   out  valid_res, address, port          valid/ready
//
// One character is taken per clock. A character is registered, then scanned
// against the parser state from the input register; a closing character hands
// a copy of the final state to the check stage, whose result is registered
// in the output register once that register is empty or being read. Reset
// (rst_n low, synchronous) empties all stages and restarts the parser. A stalled
// result only blocks input once both the check stage and the output register
// hold a result and another closing character is waiting.
module ipv4_host_port_text_parser #(
  parameter int MaxParts = ipv4hp_pkg::MAX_PARTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  ipv4hp_in_if.sink           in_bus,
  ipv4hp_out_if.source        out_bus
);
  import ipv4hp_pkg::*;

  localparam int CNT_W = $clog2(MaxParts + 1);
  localparam int IDX_W = (MaxParts > 1) ? $clog2(MaxParts) : 1;

  // ---------------------------------------------------------------- signals
  logic              in_v_r;
  logic              in_last_r;
  logic [CHAR_W-1:0] in_char_r;

  logic              fire1;
  logic              snap_free;
  logic              snap_move;
  logic              close_item;

  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  tok_t              tok_r, tok_nxt;
  logic [VAL_W-1:0]  parts_r [MaxParts];

  logic [4:0]        dig;
  logic              dig_ok;
  logic [VAL_W+3:0]  acc_mul;
  logic [VAL_W+3:0]  acc;
  tok_t              tok_num;
  tok_t              tok_fed;
  logic              push;
  logic              push_ok;
  logic [VAL_W-1:0]  push_val;
  logic              part_we;
  logic [IDX_W-1:0]  part_idx;

  logic              snap_v_r;
  logic              snap_phase_r;
  logic              snap_err_r;
  logic [CNT_W-1:0]  snap_cnt_r;
  tok_t              snap_tok_r;
  logic [VAL_W-1:0]  snap_parts_r [MaxParts];

  logic              fin_tok_ok;
  logic              fin_bad;
  logic              fin_ok;
  logic [ADDR_W-1:0] fin_addr;

  logic              out_v_r;
  logic              out_res_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [PORT_W-1:0] out_port_r;

  // ---------------------------------------------------------- flow control
  assign snap_move  = snap_v_r && (!out_v_r || out_bus.ready);
  assign snap_free  = !snap_v_r || snap_move;
  assign fire1      = in_v_r && (!in_last_r || snap_free);
  assign close_item = fire1 && in_last_r;
  assign in_bus.ready = !in_v_r || fire1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_char_r <= in_bus.character;
      in_last_r <= in_bus.is_last;
    end
  end

  // ------------------------------------------------------- digit arithmetic
  assign dig = digit_of(in_char_r);

  always_comb begin
    case (tok_r.base)
      BASE_HEX: begin
        dig_ok  = 1'b1;
        acc_mul = {tok_r.value, 4'b0};
      end
      BASE_OCT: begin
        dig_ok  = (dig < 5'd8);
        acc_mul = {1'b0, tok_r.value, 3'b0};
      end
      default: begin
        dig_ok  = (dig < 5'd10);
        acc_mul = {1'b0, tok_r.value, 3'b0} + {3'b0, tok_r.value, 1'b0};
      end
    endcase
    if (dig == NO_DIGIT) begin
      dig_ok = 1'b0;
    end
    acc = acc_mul + (VAL_W + 4)'(dig);
  end

  // First character of a number, after optional space and sign
  always_comb begin
    tok_num     = tok_r;
    tok_num.len = 1'b1;
    if (in_char_r == CH_ZERO) begin
      tok_num.sub   = TS_ZERO;
      tok_num.value = '0;
    end else if (dig < 5'd10) begin
      tok_num.sub   = TS_DIGITS;
      tok_num.base  = BASE_DEC;
      tok_num.value = VAL_W'(dig);
    end else begin
      tok_num.sub   = TS_BAD;
    end
  end

  // Token scanner: one character into the current number
  always_comb begin
    tok_fed     = tok_r;
    tok_fed.len = 1'b1;
    unique case (tok_r.sub)
      TS_START: begin
        if (is_space(in_char_r)) begin
          tok_fed.sub = TS_START;
        end else if (in_char_r == CH_PLUS || in_char_r == CH_MINUS) begin
          tok_fed.neg = (in_char_r == CH_MINUS);
          tok_fed.sub = TS_SIGN;
        end else begin
          tok_fed = tok_num;
        end
      end
      TS_SIGN: begin
        tok_fed = tok_num;
      end
      TS_ZERO: begin
        if (in_char_r == CH_X_LO || in_char_r == CH_X_UP) begin
          tok_fed.sub = TS_ZEROX;
        end else if (dig < 5'd8) begin
          tok_fed.sub   = TS_DIGITS;
          tok_fed.base  = BASE_OCT;
          tok_fed.value = VAL_W'(dig);
        end else begin
          tok_fed.sub = TS_BAD;
        end
      end
      TS_ZEROX: begin
        if (dig < 5'd16) begin
          tok_fed.sub   = TS_DIGITS;
          tok_fed.base  = BASE_HEX;
          tok_fed.value = VAL_W'(dig);
        end else begin
          tok_fed.sub = TS_BAD;
        end
      end
      TS_DIGITS: begin
        if (dig_ok) begin
          if (acc[VAL_W+3:VAL_W] != '0) begin
            tok_fed.ovf   = 1'b1;
            tok_fed.value = VAL_MAX;
          end else begin
            tok_fed.value = acc[VAL_W-1:0];
          end
        end else begin
          tok_fed.sub = TS_BAD;
        end
      end
      default: begin
        tok_fed.sub = TS_BAD;
      end
    endcase
  end

  // Closing an address part: an empty token counts as zero
  assign push_ok  = (tok_r.sub == TS_START && !tok_r.len) ||
                    ((tok_r.sub == TS_ZERO || tok_r.sub == TS_DIGITS) && !tok_r.ovf &&
                     !(tok_r.neg && tok_r.value != '0));
  assign push_val = push_ok ? tok_r.value : '0;

  // ------------------------------------------------------- parser next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    tok_nxt   = tok_r;
    push      = 1'b0;
    part_we   = 1'b0;
    part_idx  = cnt_r[IDX_W-1:0];
    if (fire1) begin
      if (!phase_r && in_char_r == CH_COLON) begin
        push      = tok_r.len;
        tok_nxt   = TOK_CLEAR;
        phase_nxt = 1'b1;
      end else if (!phase_r && in_char_r == CH_DOT) begin
        push    = 1'b1;
        tok_nxt = TOK_CLEAR;
      end else begin
        tok_nxt = tok_fed;
      end
      if (push) begin
        if (!push_ok) begin
          err_nxt = 1'b1;
        end
        if (cnt_r >= CNT_W'(MaxParts)) begin
          err_nxt = 1'b1;
        end else begin
          part_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  // Parser state; a closing character restarts it
  always_ff @(posedge clk) begin
    if (!rst_n || close_item) begin
      phase_r <= 1'b0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      tok_r   <= TOK_CLEAR;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Address part store, only entries below the count are read
  always_ff @(posedge clk) begin
    if (part_we) begin
      parts_r[part_idx] <= push_val;
    end
  end

  // ------------------------------------------------- final state snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (close_item) begin
      snap_v_r <= 1'b1;
    end else if (snap_move) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close_item) begin
      snap_phase_r <= phase_nxt;
      snap_err_r   <= err_nxt;
      snap_cnt_r   <= cnt_nxt;
      snap_tok_r   <= tok_nxt;
      for (int k = 0; k < MaxParts; k++) begin
        snap_parts_r[k] <= (part_we && part_idx == IDX_W'(k)) ? push_val : parts_r[k];
      end
    end
  end

  // ------------------------------------------------------- result checks
  assign fin_tok_ok = (snap_tok_r.sub == TS_ZERO || snap_tok_r.sub == TS_DIGITS) &&
                      !snap_tok_r.ovf && !(snap_tok_r.neg && snap_tok_r.value != '0);

  // Leading parts fill one byte each, the last one fills what is left
  always_comb begin
    fin_bad  = 1'b0;
    fin_addr = '0;
    for (int k = 0; k < MaxParts; k++) begin
      if (snap_cnt_r == CNT_W'(k + 1)) begin
        if (snap_parts_r[k] > (VAL_MAX >> (8 * k))) begin
          fin_bad = 1'b1;
        end
        fin_addr = fin_addr | snap_parts_r[k];
      end else if (snap_cnt_r > CNT_W'(k + 1)) begin
        if (snap_parts_r[k][VAL_W-1:8] != '0) begin
          fin_bad = 1'b1;
        end
        fin_addr = fin_addr | ({snap_parts_r[k][7:0], {(ADDR_W - 8){1'b0}}} >> (8 * k));
      end
    end
  end

  assign fin_ok = !snap_err_r && snap_phase_r && fin_tok_ok &&
                  (snap_tok_r.value[VAL_W-1:PORT_W] == '0) && !fin_bad;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (snap_move) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_res_r  <= fin_ok;
      out_addr_r <= fin_ok ? fin_addr : '0;
      out_port_r <= fin_ok ? snap_tok_r.value[PORT_W-1:0] : '0;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.valid_res = out_res_r;
  assign out_bus.address   = out_addr_r;
  assign out_bus.port      = out_port_r;

  // ------------------------------------------------------------ assertions
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_res_r |-> out_addr_r == '0 && out_port_r == '0)
    else $error("invalid result carries nonzero address or port");

  a_close_restart: assert property (@(posedge clk) disable iff (!rst_n)
    close_item |=> cnt_r == '0 && !phase_r && !err_r && snap_v_r)
    else $error("parser not restarted after closing character");

  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !snap_move |=> snap_v_r && $stable(snap_cnt_r) && $stable(snap_tok_r))
    else $error("pending final state lost while output stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !fire1 |=> in_v_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("held input character changed before it was scanned");

endmodule
